@@ hw/rtl/espr_pkg.sv @@
package espr_pkg;

  localparam int WINDOW_LEN  = 5;
  localparam int MOTOR_COUNT = 2;

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SLOT_W = (MOTOR_COUNT * WINDOW_LEN > 1) ?
                          $clog2(MOTOR_COUNT * WINDOW_LEN) : 1;
  localparam int SUM_W  = $clog2(WINDOW_LEN * 65535 + 1);

  localparam logic [15:0] KP_RESET       = 16'd2048;
  localparam logic [15:0] KI_RESET       = 16'd1638;
  localparam logic [23:0] SCALE_RESET    = 24'd0;
  localparam logic [15:0] MAX_DUTY_RESET = 16'd4000;

  typedef enum logic [1:0] {
    FN_TICK     = 2'd0,
    FN_STOP     = 2'd1,
    FN_CLR_ODO  = 2'd2,
    FN_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_KP       = 2'd0,
    REG_KI       = 2'd1,
    REG_SCALE    = 2'd2,
    REG_MAX_DUTY = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MSPD,
    S_ERR,
    S_MKP,
    S_MKI,
    S_PI,
    S_OUT
  } state_t;

endpackage

@@ hw/rtl/encoder_speed_pi_regulator.sv @@
// Speed tick: the request steps through EXEC, MSPD, ERR, MKP, MKI, PI and OUT;
// the next request is taken only after the result is loaded (one shared
// 27x25 multiplier used three times: speed scaling, kp term, ki term).
// Stop / clear-odometry / unused code: the request steps through EXEC and OUT.
// A pending result in the output register only delays the next load.
// Synchronous active-low reset clears the FSM, per-motor state and windows.
module encoder_speed_pi_regulator
  import espr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_motor,
  input  logic [15:0] in_encoder_count,
  input  logic signed [15:0] in_target_speed,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_motor_out,
  output logic [15:0] out_duty,
  output logic [23:0] out_speed,
  output logic [31:0] out_odometry
);

  state_t state_r, state_nxt;

  logic [15:0] kp_r, ki_r, max_duty_r;
  logic [23:0] scale_r;

  func_t       func_r;
  logic        m_r;
  logic [15:0] cnt_r;
  logic [15:0] tgt_r;

  logic [15:0]       win_r       [MOTOR_COUNT*WINDOW_LEN];
  logic [SUM_W-1:0]  win_sum_r   [MOTOR_COUNT];
  logic [POS_W-1:0]  win_pos_r   [MOTOR_COUNT];
  logic [31:0]       odo_r       [MOTOR_COUNT];
  logic [23:0]       duty_acc_r  [MOTOR_COUNT];
  logic signed [25:0] prev_err_r [MOTOR_COUNT];
  logic [23:0]       speed_r     [MOTOR_COUNT];

  logic signed [25:0] e_r;
  logic signed [51:0] prod_r, pacc_r;

  logic        out_valid_r;
  logic        out_motor_r;
  logic [15:0] out_duty_r;
  logic [23:0] out_speed_r;
  logic [31:0] out_odo_r;

  logic               motor_ok;
  logic               out_free;
  logic [POS_W-1:0]   pos_cur, pos_next;
  logic [POS_W:0]     pos_inc;
  logic [SLOT_W-1:0]  slot;
  logic [23:0]        spd_sat;
  logic signed [25:0] e_nxt;
  logic signed [26:0] diff;
  logic signed [26:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] pi_sum;
  logic signed [41:0] acc_w, top_w;
  logic [23:0]        acc_clamped;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign motor_ok  = ({31'd0, m_r} < 32'(MOTOR_COUNT));

  // window slot for this motor
  always_comb begin
    if ({1'b0, win_pos_r[m_r]} >= (POS_W+1)'(WINDOW_LEN))
      pos_cur = '0;
    else
      pos_cur = win_pos_r[m_r];
    pos_inc  = {1'b0, pos_cur} + (POS_W+1)'(1);
    pos_next = (pos_inc >= (POS_W+1)'(WINDOW_LEN)) ? '0 : pos_inc[POS_W-1:0];
    slot     = SLOT_W'(WINDOW_LEN) * SLOT_W'(m_r) + SLOT_W'(pos_cur);
  end

  // speed = (sum * scale) >> 8, saturated to 24 bits
  assign spd_sat = (|prod_r[51:32]) ? 24'hFF_FFFF : prod_r[31:8];
  assign e_nxt   = $signed({{2{tgt_r[15]}}, tgt_r, 8'h00}) - $signed({2'b00, spd_sat});
  assign diff    = $signed({e_r[25], e_r}) - $signed({prev_err_r[m_r][25], prev_err_r[m_r]});

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MSPD: begin
        mul_a = $signed(27'(win_sum_r[m_r]));
        mul_b = $signed({1'b0, scale_r});
      end
      S_MKP: begin
        mul_a = diff;
        mul_b = $signed({9'd0, kp_r});
      end
      default: begin
        mul_a = $signed({e_r[25], e_r});
        mul_b = $signed({9'd0, ki_r});
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // delta = floor(sum / 4096); arithmetic shift gives the floor
  assign pi_sum = pacc_r + prod_r;
  assign acc_w  = $signed({18'd0, duty_acc_r[m_r]}) +
                  $signed({{2{pi_sum[51]}}, pi_sum[51:12]});
  assign top_w  = $signed({18'd0, max_duty_r, 8'h00});

  always_comb begin
    if (acc_w[41])
      acc_clamped = '0;
    else if (acc_w > top_w)
      acc_clamped = {max_duty_r, 8'h00};
    else
      acc_clamped = acc_w[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= S_IDLE;
    else
      state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid)
          state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (motor_ok && func_r == FN_TICK)
          state_nxt = S_MSPD;
        else
          state_nxt = S_OUT;
      end
      S_MSPD:  state_nxt = S_ERR;
      S_ERR:   state_nxt = S_MKP;
      S_MKP:   state_nxt = S_MKI;
      S_MKI:   state_nxt = S_PI;
      S_PI:    state_nxt = S_OUT;
      S_OUT: begin
        if (out_free)
          state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= KP_RESET;
      ki_r       <= KI_RESET;
      scale_r    <= SCALE_RESET;
      max_duty_r <= MAX_DUTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_KP:       kp_r       <= cfg_data[15:0];
        REG_KI:       ki_r       <= cfg_data[15:0];
        REG_SCALE:    scale_r    <= cfg_data;
        REG_MAX_DUTY: max_duty_r <= cfg_data[15:0];
        default:      ;
      endcase
    end
  end

  // request capture and multiplier pipeline registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      func_r <= func_t'(in_func);
      m_r    <= in_motor;
      cnt_r  <= in_encoder_count;
      tgt_r  <= in_target_speed;
    end
    if (state_r == S_MSPD || state_r == S_MKP || state_r == S_MKI)
      prod_r <= prod;
    if (state_r == S_MKI)
      pacc_r <= prod_r;
    if (state_r == S_ERR)
      e_r <= e_nxt;
  end

  // per-motor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_COUNT * WINDOW_LEN; i++)
        win_r[i] <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        win_sum_r[i]  <= '0;
        win_pos_r[i]  <= '0;
        odo_r[i]      <= '0;
        duty_acc_r[i] <= '0;
        prev_err_r[i] <= '0;
        speed_r[i]    <= '0;
      end
    end else begin
      case (state_r)
        S_EXEC: begin
          if (motor_ok) begin
            case (func_r)
              FN_TICK: begin
                odo_r[m_r]     <= odo_r[m_r] + 32'(cnt_r);
                win_sum_r[m_r] <= win_sum_r[m_r] - SUM_W'(win_r[slot]) + SUM_W'(cnt_r);
                win_r[slot]    <= cnt_r;
                win_pos_r[m_r] <= pos_next;
              end
              FN_STOP: begin
                duty_acc_r[m_r] <= '0;
                prev_err_r[m_r] <= '0;
              end
              FN_CLR_ODO: odo_r[m_r] <= '0;
              default: ;
            endcase
          end
        end
        S_ERR: speed_r[m_r] <= spd_sat;
        S_PI: begin
          duty_acc_r[m_r] <= acc_clamped;
          prev_err_r[m_r] <= e_r;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_motor_r <= m_r;
      if (motor_ok) begin
        out_duty_r  <= duty_acc_r[m_r][23:8];
        out_speed_r <= speed_r[m_r];
        out_odo_r   <= odo_r[m_r];
      end else begin
        out_duty_r  <= '0;
        out_speed_r <= '0;
        out_odo_r   <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_motor_out = out_motor_r;
  assign out_duty      = out_duty_r;
  assign out_speed     = out_speed_r;
  assign out_odometry  = out_odo_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_EXEC)
    else $error("accepted request did not start execution");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PI |=> duty_acc_r[m_r] <= {max_duty_r, 8'h00})
    else $error("duty accumulator above clamp after PI step");

  a_prev_err: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PI |=> prev_err_r[m_r] == $past(e_r))
    else $error("previous error not updated");

endmodule

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import espr_pkg::*;

  localparam int     STALL_LIMIT = 5000;
  localparam int     HOLD_CYCLES = 300;
  localparam longint SPEED_CEIL  = 64'hFF_FFFF;

  typedef struct packed {
    func_t              fn;
    logic               motor;
    logic [15:0]        count;
    logic signed [15:0] target;
  } wheel_req_t;

  typedef struct packed {
    logic        motor;
    logic [15:0] duty;
    logic [23:0] speed;
    logic [31:0] odo;
  } wheel_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_KP;
  logic [23:0] cfg_data = '0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FN_NONE;
  logic        in_motor = 1'b0;
  logic [15:0] in_encoder_count = '0;
  logic signed [15:0] in_target_speed = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_motor_out;
  logic [15:0] out_duty;
  logic [23:0] out_speed;
  logic [31:0] out_odometry;

  encoder_speed_pi_regulator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_motor         (in_motor),
    .in_encoder_count (in_encoder_count),
    .in_target_speed  (in_target_speed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_motor_out    (out_motor_out),
    .out_duty         (out_duty),
    .out_speed        (out_speed),
    .out_odometry     (out_odometry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // regulator shadow: configuration and per-motor state
  longint      kp_q12, ki_q12, scale_q16, duty_cap;
  longint      win_cnt [MOTOR_COUNT][WINDOW_LEN];
  longint      win_total [MOTOR_COUNT];
  int          win_slot [MOTOR_COUNT];
  logic [31:0] odo_total [MOTOR_COUNT];
  longint      duty_q8 [MOTOR_COUNT];
  longint      err_prev [MOTOR_COUNT];
  longint      speed_q8 [MOTOR_COUNT];

  wheel_req_t  pending_req [$];
  wheel_rsp_t  due_result [$];

  wheel_req_t  took_req, next_req;
  wheel_rsp_t  took_rsp, seen_rsp;
  int          send_gap;
  int          stall_run;
  int          hold_left;
  logic        hold_done;
  int          idle_cycles;

  int          results_seen = 0;
  int          mismatch_count = 0;
  int          cfg_writes = 0;
  int          n_tick = 0, n_stop = 0, n_clear = 0, n_unused = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic advance_regulator(input wheel_req_t r, output wheel_rsp_t x);
    int     m;
    longint cnt, tgt, sp, err, delta, acc;
    m   = r.motor;
    cnt = r.count;
    tgt = $signed(r.target);
    case (r.fn)
      FN_TICK: begin
        odo_total[m] = odo_total[m] + r.count;
        win_total[m] = win_total[m] - win_cnt[m][win_slot[m]] + cnt;
        win_cnt[m][win_slot[m]] = cnt;
        win_slot[m] = (win_slot[m] + 1 == WINDOW_LEN) ? 0 : win_slot[m] + 1;
        sp = (win_total[m] * scale_q16) >>> 8;
        if (sp > SPEED_CEIL) sp = SPEED_CEIL;
        speed_q8[m] = sp;
        err = tgt * 256 - sp;
        // arithmetic shift gives floor division for negative sums
        delta = (kp_q12 * (err - err_prev[m]) + ki_q12 * err) >>> 12;
        acc = duty_q8[m] + delta;
        if (acc > duty_cap * 256) acc = duty_cap * 256;
        if (acc < 0) acc = 0;
        duty_q8[m]  = acc;
        err_prev[m] = err;
      end
      FN_STOP: begin
        duty_q8[m]  = 0;
        err_prev[m] = 0;
      end
      FN_CLR_ODO: odo_total[m] = '0;
      default: ;
    endcase
    x.motor = r.motor;
    x.duty  = duty_q8[m][23:8];
    x.speed = speed_q8[m][23:0];
    x.odo   = odo_total[m];
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        took_req.fn     = func_t'(in_func);
        took_req.motor  = in_motor;
        took_req.count  = in_encoder_count;
        took_req.target = in_target_speed;
        advance_regulator(took_req, took_rsp);
        due_result.push_back(took_rsp);
        case (took_req.fn)
          FN_TICK:    n_tick++;
          FN_STOP:    n_stop++;
          FN_CLR_ODO: n_clear++;
          default:    n_unused++;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_req.size() != 0) begin
          next_req = pending_req.pop_front();
          in_func          <= next_req.fn;
          in_motor         <= next_req.motor;
          in_encoder_count <= next_req.count;
          in_target_speed  <= next_req.target;
          in_valid         <= 1'b1;
          send_gap         <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 120) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (!out_stall && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_run <= pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(0, 30);
    end
  end

  task automatic check_field(string field, longint want_v, longint got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch #%0d at %0t ns: %s expected %0d got %0d",
                 mismatch_count, $time, field, want_v, got_v);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (due_result.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch #%0d at %0t ns: result with no request outstanding",
                   mismatch_count, $time);
      end else begin
        seen_rsp = due_result.pop_front();
        check_field("motor_out", seen_rsp.motor, out_motor_out);
        check_field("duty", seen_rsp.duty, out_duty);
        check_field("speed", seen_rsp.speed, out_speed);
        check_field("odometry", seen_rsp.odo, out_odometry);
      end
    end
  end

  // watchdog: no handshake of any kind for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without progress, %0d results outstanding",
               idle_cycles, due_result.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [23:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_KP:       kp_q12    = value[15:0];
      REG_KI:       ki_q12    = value[15:0];
      REG_SCALE:    scale_q16 = value;
      REG_MAX_DUTY: duty_cap  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_req(func_t f, logic m, logic [15:0] c, logic [15:0] t);
    wheel_req_t r;
    r.fn     = f;
    r.motor  = m;
    r.count  = c;
    r.target = t;
    pending_req.push_back(r);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_req.size() != 0 || in_valid || due_result.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic run_phase(longint kp, longint ki, longint scale, longint cap,
                           int n_items);
    wheel_req_t  r;
    int          pick;
    logic [15:0] cruise [MOTOR_COUNT];
    write_reg(REG_KP, kp[23:0]);
    write_reg(REG_KI, ki[23:0]);
    write_reg(REG_SCALE, scale[23:0]);
    write_reg(REG_MAX_DUTY, cap[23:0]);
    foreach (cruise[i]) cruise[i] = 16'($urandom_range(0, 4000));
    @(negedge clk);
    repeat (n_items) begin
      r.motor = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 78)      r.fn = FN_TICK;
      else if (pick < 85) r.fn = FN_STOP;
      else if (pick < 92) r.fn = FN_CLR_ODO;
      else                r.fn = FN_NONE;
      // steady wheel rates with jitter, plus full-range and extreme counts
      pick = $urandom_range(0, 99);
      if (pick < 45)      r.count = cruise[r.motor] + 16'($urandom_range(0, 64));
      else if (pick < 75) r.count = 16'($urandom_range(0, 65535));
      else if (pick < 88) r.count = 16'h0000;
      else                r.count = 16'hFFFF;
      pick = $urandom_range(0, 99);
      if (pick < 50) r.target = 16'($urandom_range(0, 4000) - 2000);
      else           r.target = 16'($urandom_range(0, 65535));
      pending_req.push_back(r);
    end
    wait_drained();
  endtask

  initial begin
    kp_q12    = KP_RESET;
    ki_q12    = KI_RESET;
    scale_q16 = SCALE_RESET;
    duty_cap  = MAX_DUTY_RESET;
    for (int m = 0; m < MOTOR_COUNT; m++) begin
      for (int s = 0; s < WINDOW_LEN; s++) win_cnt[m][s] = 0;
      win_total[m] = 0;
      win_slot[m]  = 0;
      odo_total[m] = '0;
      duty_q8[m]   = 0;
      err_prev[m]  = 0;
      speed_q8[m]  = 0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero speed scale, so the error is the target alone
    @(negedge clk);
    queue_req(FN_NONE, 1'b0, 16'hFFFF, 16'h7FFF);
    queue_req(FN_NONE, 1'b1, 16'h0000, 16'h8000);
    queue_req(FN_TICK, 1'b0, 16'hFFFF, 16'h7FFF);
    queue_req(FN_TICK, 1'b1, 16'hFFFF, 16'h8000);
    repeat (6) queue_req(FN_TICK, 1'b0, 16'hFFFF, 16'd100);
    queue_req(FN_TICK, 1'b1, 16'h0000, 16'h0000);
    queue_req(FN_STOP, 1'b0, 16'hFFFF, 16'h7FFF);
    queue_req(FN_NONE, 1'b0, 16'h0000, 16'h0000);
    queue_req(FN_CLR_ODO, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_req(FN_NONE, 1'b1, 16'h0000, 16'h0000);
    queue_req(FN_TICK, 1'b1, 16'h0001, 16'h0001);
    queue_req(FN_STOP, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_req(FN_CLR_ODO, 1'b0, 16'h0000, 16'h0000);
    queue_req(FN_TICK, 1'b0, 16'h8000, 16'h7FFF);
    queue_req(FN_NONE, 1'b1, 16'hFFFF, 16'h8000);
    wait_drained();

    // full-scale gains and scaling: speed saturates
    run_phase(65535, 65535, 24'hFF_FFFF, 65535, 150);
    // everything zero: clamp at 0 pulls accumulators down
    run_phase(0, 0, 0, 0, 60);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 8192), $urandom_range(0, 65535), 150);
    run_phase(KP_RESET, KI_RESET, $urandom_range(256, 4096), 100, 150);
    run_phase($urandom_range(0, 8192), $urandom_range(0, 8192),
              $urandom_range(0, 24'hFF_FFFF), 65535, 150);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 2048), $urandom_range(0, 4000), 100);

    $display("covered %0d speed ticks, %0d motor stops, %0d odometry clears, %0d unused codes",
             n_tick, n_stop, n_clear, n_unused);
    $display("%0d results compared across %0d register writes and one long output hold-off",
             results_seen, cfg_writes);
    if (mismatch_count == 0 && due_result.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/espr_pkg.sv
hw/rtl/encoder_speed_pi_regulator.sv
bench/testbench.sv
